@@ sv/tpe_pkg.sv @@
package tpe_pkg;

  localparam int MAX_DIMS     = 4;
  localparam int BUFFER_DEPTH = 4096;
  localparam int DATA_WIDTH   = 32;

  localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int EXT_W     = 13;
  localparam int SUM_W     = ADDR_W + $clog2(MAX_DIMS);
  localparam int DIM_IDX_W = $clog2(MAX_DIMS);
  localparam int NDIM_W    = 3;
  localparam int ORDER_W   = 8;
  localparam int SEQ_W     = $clog2(2 * MAX_DIMS + 1);

  localparam int REG_COUNT = 6;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM3 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIM_ORDER = 3'd5;

  localparam logic [NDIM_W-1:0]  NUM_DIMS_RST  = 3'd2;
  localparam logic [EXT_W-1:0]   SIZE_RST      = 13'd1;
  localparam logic [ORDER_W-1:0] DIM_ORDER_RST = 8'd228;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_ORDER = 2'd1;
  localparam logic [1:0] ERR_SIZE  = 2'd2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_DRAIN = 1'b1
  } tpe_cmd_e;

  typedef struct packed {
    logic                               busy;
    logic                               clr;
    logic                               order_err;
    logic                               ovf;
    logic [NDIM_W-1:0]                  ndims;
    logic [CNT_W-1:0]                   total;
    logic [MAX_DIMS-1:0][EXT_W-1:0]     ext_out;
    logic [MAX_DIMS-1:0][SUM_W:0]       delta;
  } tpe_geom_t;

endpackage

@@ sv/tpe_cfg.sv @@
module tpe_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpe_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpe_pkg::PDATA_W-1:0]   pwdata,
  output logic [tpe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tpe_pkg::tpe_geom_t            geom_o
);
  import tpe_pkg::*;

  logic [NDIM_W-1:0]              num_dims_q;
  logic [MAX_DIMS-1:0][EXT_W-1:0] size_q;
  logic [ORDER_W-1:0]             dim_order_q;

  logic [REG_IDX_W-1:0]               reg_idx;
  logic                               reg_wr;
  logic [NDIM_W-1:0]                  ndims;
  logic [MAX_DIMS-1:0][EXT_W-1:0]     ext;
  logic [MAX_DIMS-1:0][DIM_IDX_W-1:0] ord;
  logic [MAX_DIMS-1:0][EXT_W-1:0]     ext_out;
  logic                               order_err;

  logic [SEQ_W-1:0]                   step_q;
  logic [EXT_W-1:0]                   acc_q;
  logic                               ovf_q;
  logic [SUM_W-1:0]                   suf_q;
  logic [MAX_DIMS-1:0][EXT_W-1:0]     stride_q;
  logic [MAX_DIMS-1:0][SUM_W:0]       delta_q;

  logic                               busy;
  logic                               phase_b;
  logic [DIM_IDX_W-1:0]               pos;
  logic                               in_use;
  logic [EXT_W-1:0]                   acc_in;
  logic                               ovf_in;
  logic [SUM_W-1:0]                   suf_in;
  logic [2*EXT_W-1:0]                 prod_a;
  logic [EXT_W-1:0]                   stride_sel;
  logic [2*EXT_W-1:0]                 prod_b;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && (reg_idx < REG_IDX_W'(REG_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= NUM_DIMS_RST;
      size_q      <= {MAX_DIMS{SIZE_RST}};
      dim_order_q <= DIM_ORDER_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_NUM_DIMS:  num_dims_q  <= pwdata[NDIM_W-1:0];
        REG_SIZE_DIM0: size_q[0]   <= pwdata[EXT_W-1:0];
        REG_SIZE_DIM1: size_q[1]   <= pwdata[EXT_W-1:0];
        REG_SIZE_DIM2: size_q[2]   <= pwdata[EXT_W-1:0];
        REG_SIZE_DIM3: size_q[3]   <= pwdata[EXT_W-1:0];
        REG_DIM_ORDER: dim_order_q <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUM_DIMS:  prdata = PDATA_W'(num_dims_q);
      REG_SIZE_DIM0: prdata = PDATA_W'(size_q[0]);
      REG_SIZE_DIM1: prdata = PDATA_W'(size_q[1]);
      REG_SIZE_DIM2: prdata = PDATA_W'(size_q[2]);
      REG_SIZE_DIM3: prdata = PDATA_W'(size_q[3]);
      REG_DIM_ORDER: prdata = PDATA_W'(dim_order_q);
      default:       prdata = '0;
    endcase
  end

  // Decoded geometry: zero counts and extents behave as one, and a count above four is taken as four.
  always_comb begin
    if (num_dims_q == '0) begin
      ndims = NDIM_W'(1);
    end else if (num_dims_q > NDIM_W'(MAX_DIMS)) begin
      ndims = NDIM_W'(MAX_DIMS);
    end else begin
      ndims = num_dims_q;
    end
    order_err = 1'b0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      ext[i]     = (size_q[i] == '0) ? EXT_W'(1) : size_q[i];
      ord[i]     = dim_order_q[2*i +: 2];
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      ext_out[i] = ext[ord[i]];
      if ((NDIM_W'(i) < ndims) && (NDIM_W'(ord[i]) >= ndims)) begin
        order_err = 1'b1;
      end
    end
  end

  // The first half of the sequence builds the input strides from the innermost
  // dimension outwards; the second half builds the address step taken when each
  // output index advances and all inner ones wrap.
  assign busy       = (step_q < SEQ_W'(2 * MAX_DIMS));
  assign phase_b    = step_q[DIM_IDX_W];
  assign pos        = DIM_IDX_W'(MAX_DIMS - 1) - step_q[DIM_IDX_W-1:0];
  assign in_use     = (NDIM_W'(pos) < ndims);
  assign acc_in     = (step_q == '0) ? EXT_W'(1) : acc_q;
  assign ovf_in     = (step_q == '0) ? 1'b0 : ovf_q;
  assign suf_in     = (step_q == SEQ_W'(MAX_DIMS)) ? '0 : suf_q;
  assign prod_a     = acc_in * ext[pos];
  assign stride_sel = stride_q[ord[pos]];
  assign prod_b     = (ext_out[pos] - EXT_W'(1)) * stride_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (reg_wr) begin
      step_q <= '0;
    end else if (busy) begin
      step_q <= step_q + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy && !phase_b) begin
      if (in_use) begin
        stride_q[pos] <= acc_in;
        acc_q         <= prod_a[EXT_W-1:0];
        ovf_q         <= ovf_in | (prod_a > (2*EXT_W)'(BUFFER_DEPTH));
      end else begin
        stride_q[pos] <= EXT_W'(1);
        acc_q         <= acc_in;
        ovf_q         <= ovf_in;
      end
    end else if (busy && phase_b) begin
      if (in_use) begin
        delta_q[pos] <= (SUM_W+1)'(stride_sel) - (SUM_W+1)'(suf_in);
        suf_q        <= suf_in + prod_b[SUM_W-1:0];
      end else begin
        delta_q[pos] <= '0;
        suf_q        <= suf_in;
      end
    end
  end

  assign geom_o.busy      = busy;
  assign geom_o.clr       = reg_wr;
  assign geom_o.order_err = order_err;
  assign geom_o.ovf       = ovf_q;
  assign geom_o.ndims     = ndims;
  assign geom_o.total     = CNT_W'(acc_q);
  assign geom_o.ext_out   = ext_out;
  assign geom_o.delta     = delta_q;

endmodule

@@ sv/tpe_core.sv @@
module tpe_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tpe_pkg::tpe_geom_t              geom_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tpe_pkg::tpe_cmd_e               cmd_i,
  input  logic [tpe_pkg::DATA_WIDTH-1:0]  element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tpe_pkg::DATA_WIDTH-1:0]  out_value_o,
  output logic                            last_out_o,
  output logic [1:0]                      error_o
);
  import tpe_pkg::*;

  logic [DATA_WIDTH-1:0]           store_q [BUFFER_DEPTH];
  logic [DATA_WIDTH-1:0]           rd_q;

  logic [CNT_W-1:0]                load_cnt_q;
  logic [MAX_DIMS-1:0][ADDR_W-1:0] idx_q;
  logic [SUM_W-1:0]                addr_q;

  logic                            s1_valid_q;
  logic                            s1_last_q;
  logic [1:0]                      s1_err_q;
  logic                            out_valid_q;
  logic [DATA_WIDTH-1:0]           out_value_q;
  logic                            out_last_q;
  logic [1:0]                      out_err_q;

  logic                            move;
  logic                            accept;
  logic                            is_load;
  logic                            load_full;
  logic                            wr_en;
  logic [ADDR_W-1:0]               wr_addr;
  logic                            rd_en;
  logic [MAX_DIMS-1:0]             at_max;
  logic                            last;
  logic [DIM_IDX_W-1:0]            step_pos;
  logic [1:0]                      drain_err;
  logic [1:0]                      res_err;
  logic                            res_valid;

  assign move       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = geom_i.busy || (s1_valid_q && !move);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = (cmd_i == CMD_LOAD);
  assign load_full  = (load_cnt_q >= geom_i.total);
  assign wr_addr    = load_full ? '0 : load_cnt_q[ADDR_W-1:0];

  always_comb begin
    step_pos = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      at_max[i] = (NDIM_W'(i) >= geom_i.ndims) ||
                  (EXT_W'(idx_q[i]) == geom_i.ext_out[i] - EXT_W'(1));
      if (!at_max[i]) begin
        step_pos = DIM_IDX_W'(i);
      end
    end
  end

  assign last = &at_max;

  always_comb begin
    priority if (geom_i.order_err) begin
      drain_err = ERR_ORDER;
    end else if (geom_i.ovf || (load_cnt_q < geom_i.total) ||
                 (addr_q >= SUM_W'(geom_i.total))) begin
      drain_err = ERR_SIZE;
    end else begin
      drain_err = ERR_NONE;
    end
  end

  assign res_err   = is_load ? (geom_i.ovf ? ERR_SIZE : ERR_NONE) : drain_err;
  assign res_valid = accept && (!is_load || geom_i.ovf);
  assign wr_en     = accept && is_load && !geom_i.ovf;
  assign rd_en     = accept && !is_load && (drain_err == ERR_NONE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= element_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= store_q[addr_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      idx_q      <= '0;
      addr_q     <= '0;
    end else if (geom_i.clr) begin
      load_cnt_q <= '0;
      idx_q      <= '0;
      addr_q     <= '0;
    end else if (wr_en) begin
      if (load_full) begin
        load_cnt_q <= CNT_W'(1);
        idx_q      <= '0;
        addr_q     <= '0;
      end else begin
        load_cnt_q <= load_cnt_q + CNT_W'(1);
      end
    end else if (rd_en) begin
      if (last) begin
        idx_q  <= '0;
        addr_q <= '0;
      end else begin
        for (int j = 0; j < MAX_DIMS; j++) begin
          if (DIM_IDX_W'(j) > step_pos) begin
            idx_q[j] <= '0;
          end
        end
        idx_q[step_pos] <= idx_q[step_pos] + ADDR_W'(1);
        addr_q <= SUM_W'((SUM_W+1)'(addr_q) + geom_i.delta[step_pos]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_valid) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      s1_last_q <= !is_load && last && (drain_err == ERR_NONE);
      s1_err_q  <= res_err;
    end
    if (move) begin
      out_value_q <= (s1_err_q == ERR_NONE) ? rd_q : '0;
      out_last_q  <= s1_last_q;
      out_err_q   <= s1_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign last_out_o  = out_last_q;
  assign error_o     = out_err_q;

endmodule

@@ sv/tensor_permute_engine.sv @@
// Permutes a row-major tensor of up to four dimensions held in an on-chip
// buffer of 4096 32-bit elements: load items fill the buffer in input order,
// drain items return the elements in row-major order of the permuted tensor,
// the last one flagged, with an error code for a bad dimension order, an
// oversized tensor or a drain before the load is complete. One item is taken
// per clock cycle while neither the sequencer nor a stalled output holds the
// input; a result passes through the synchronous buffer read and then the
// output register. Drain addresses come from an accumulator that adds one
// precomputed step per element, so no multiply stands in the item path.
// After reset and after every register write the block stalls input while a
// small sequencer rebuilds the strides and address steps.
module tensor_permute_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tpe_pkg::tpe_cmd_e               cmd_i,
  input  logic [tpe_pkg::DATA_WIDTH-1:0]  element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tpe_pkg::DATA_WIDTH-1:0]  out_value_o,
  output logic                            last_out_o,
  output logic [1:0]                      error_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpe_pkg::PADDR_W-1:0]     paddr,
  input  logic [tpe_pkg::PDATA_W-1:0]     pwdata,
  output logic [tpe_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import tpe_pkg::*;

  tpe_geom_t geom;

  tpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  tpe_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .geom_i          (geom),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_value_o     (out_value_o),
    .last_out_o      (last_out_o),
    .error_o         (error_o)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom.busy |-> in_stall_o)
    else $error("item path open while geometry is rebuilt");

  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[PADDR_W-1:2] < REG_IDX_W'(REG_COUNT)))
    |=> in_stall_o)
    else $error("register write did not stall the item path");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_o != ERR_NONE)) |-> ((out_value_o == '0) && !last_out_o))
    else $error("error result carries data or a last flag");
`endif

endmodule

@@ test/tensor_permute_engine_test.sv @@
module tensor_permute_engine_test;
  import tpe_pkg::*;

  localparam int ITEM_TARGET   = 1400;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] elem;
    logic                  last;
    logic [1:0]            err;
  } permute_result_t;

  // Tracks the register file, the element buffer and the drain walk, and keeps
  // the results that accepted items are owed.
  class permute_tracker;
    logic [31:0]           reg_file [REG_COUNT];
    logic [DATA_WIDTH-1:0] elements [BUFFER_DEPTH];
    int unsigned           load_count;
    int unsigned           out_index [MAX_DIMS];
    longint unsigned       drain_count;
    permute_result_t       awaited [$];
    int                    errors;

    function new();
      reg_file[REG_NUM_DIMS]  = 32'(NUM_DIMS_RST);
      reg_file[REG_SIZE_DIM0] = 32'(SIZE_RST);
      reg_file[REG_SIZE_DIM1] = 32'(SIZE_RST);
      reg_file[REG_SIZE_DIM2] = 32'(SIZE_RST);
      reg_file[REG_SIZE_DIM3] = 32'(SIZE_RST);
      reg_file[REG_DIM_ORDER] = 32'(DIM_ORDER_RST);
      load_count = 0;
      errors     = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      foreach (out_index[i]) out_index[i] = 0;
      drain_count = 0;
    endfunction

    function logic [31:0] field_mask(int idx);
      case (idx)
        REG_NUM_DIMS: return 32'h7;
        REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3: return 32'h1FFF;
        REG_DIM_ORDER: return 32'hFF;
        default: return 32'h0;
      endcase
    endfunction

    function int dims_in_use();
      int n;
      n = int'(reg_file[REG_NUM_DIMS]);
      if (n == 0) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      return n;
    endfunction

    function longint unsigned extent(int d);
      longint unsigned s;
      s = 64'(reg_file[REG_SIZE_DIM0 + d]);
      return (s == 0) ? 1 : s;
    endfunction

    function int order_field(int i);
      return int'((reg_file[REG_DIM_ORDER] >> (2 * i)) & 32'h3);
    endfunction

    function longint unsigned elements_in_tensor();
      longint unsigned t;
      t = 1;
      for (int d = 0; d < dims_in_use(); d++) t *= extent(d);
      return t;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx >= REG_COUNT) return;
      reg_file[idx] = value & field_mask(idx);
      load_count = 0;
      clear_walk();
    endfunction

    function void take_item(tpe_cmd_e cmd, logic [DATA_WIDTH-1:0] value);
      int n;
      int d;
      longint unsigned total;
      longint unsigned out_total;
      longint unsigned addr;
      longint unsigned stride [MAX_DIMS];
      longint unsigned span [MAX_DIMS];
      permute_result_t r;
      n = dims_in_use();
      total = elements_in_tensor();
      r = '{elem: '0, last: 1'b0, err: ERR_NONE};
      if (cmd == CMD_LOAD) begin
        if (total > BUFFER_DEPTH) begin
          r.err = ERR_SIZE;
          awaited.push_back(r);
          return;
        end
        if (load_count >= total) begin
          load_count = 0;
          clear_walk();
        end
        elements[load_count % BUFFER_DEPTH] = value;
        load_count++;
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (order_field(i) >= n) begin
          r.err = ERR_ORDER;
          awaited.push_back(r);
          return;
        end
      end
      if (total > BUFFER_DEPTH || load_count < total) begin
        r.err = ERR_SIZE;
        awaited.push_back(r);
        return;
      end
      stride[n-1] = 1;
      for (int k = n - 2; k >= 0; k--) stride[k] = stride[k+1] * extent(k + 1);
      out_total = 1;
      addr = 0;
      for (int i = 0; i < n; i++) begin
        d = order_field(i);
        span[i] = extent(d);
        out_total *= span[i];
        addr += out_index[i] * stride[d];
      end
      if (addr >= total) begin
        r.err = ERR_SIZE;
        awaited.push_back(r);
        return;
      end
      r.elem = elements[addr % BUFFER_DEPTH];
      if (drain_count + 1 >= out_total) begin
        r.last = 1'b1;
        clear_walk();
      end else begin
        drain_count++;
        for (int k = n - 1; k >= 0; k--) begin
          out_index[k]++;
          if (out_index[k] < span[k]) break;
          out_index[k] = 0;
        end
      end
      awaited.push_back(r);
    endfunction

    function void complain(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(logic [DATA_WIDTH-1:0] v, logic l, logic [1:0] e);
      permute_result_t want;
      if (awaited.size() == 0) begin
        complain($sformatf("result with none awaited: value %h last %b error %0d", v, l, e));
        return;
      end
      want = awaited.pop_front();
      if (want.elem !== v || want.last !== l || want.err !== e)
        complain($sformatf("result: expected value %h last %b error %0d, got %h %b %0d",
                           want.elem, want.last, want.err, v, l, e));
    endfunction

    function void check_reg(int idx, logic [31:0] got);
      if (got !== reg_file[idx])
        complain($sformatf("register %0d read: expected %h, got %h", idx, reg_file[idx], got));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  tpe_cmd_e               cmd_i;
  logic [DATA_WIDTH-1:0]  element_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [DATA_WIDTH-1:0]  out_value_o;
  logic                   last_out_o;
  logic [1:0]             error_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  permute_tracker tracker = new();
  int items_sent;
  int quiet_cycles;
  bit gaps_on;
  bit stall_on;

  tensor_permute_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_value_o     (out_value_o),
    .last_out_o      (last_out_o),
    .error_o         (error_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) tracker.take_item(cmd_i, element_value_i);
    if (out_valid_o && !out_stall_i) tracker.check_result(out_value_o, last_out_o, error_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tensor_permute_engine_test: done, errors");
    $finish;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(tpe_cmd_e c, logic [DATA_WIDTH-1:0] v);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    element_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] field);
    logic [31:0] word;
    word = ($urandom() & ~tracker.field_mask(int'(idx))) | field;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(int'(idx), word);
  endtask

  task automatic reg_check(logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.check_reg(int'(idx), prdata);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(logic [2:0] nd, logic [12:0] s0, logic [12:0] s1,
                              logic [12:0] s2, logic [12:0] s3, logic [7:0] ord);
    settle();
    reg_write(REG_NUM_DIMS, 32'(nd));
    reg_write(REG_SIZE_DIM0, 32'(s0));
    reg_write(REG_SIZE_DIM1, 32'(s1));
    reg_write(REG_SIZE_DIM2, 32'(s2));
    reg_write(REG_SIZE_DIM3, 32'(s3));
    reg_write(REG_DIM_ORDER, 32'(ord));
    for (int r = 0; r < REG_COUNT; r++) reg_check(REG_IDX_W'(r));
    apb_release();
  endtask

  initial begin : stimulus
    int n;
    int kind;
    int cap;
    int j;
    int tmp;
    int perm [MAX_DIMS];
    logic [2:0] nd;
    logic [12:0] sz [MAX_DIMS];
    logic [7:0] ord;
    longint unsigned total;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cmd_i           <= CMD_LOAD;
    element_value_i <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry is a single element: an early drain, then load, drain and replay,
    // then a load into the full tensor starts a new one.
    send_item(CMD_DRAIN, $urandom());
    send_item(CMD_LOAD, 32'hFFFF_FFFF);
    send_item(CMD_DRAIN, 32'h0);
    send_item(CMD_DRAIN, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 32'h0);
    send_item(CMD_DRAIN, $urandom());

    // A 2 by 3 transpose, with writes to unused addresses between load and drain.
    apply_config(3'd2, 13'd2, 13'd3, 13'd1, 13'd1, 8'hE1);
    repeat (6) send_item(CMD_LOAD, $urandom());
    settle();
    reg_write(REG_SPARE_LO, 32'h0);
    reg_write(REG_SPARE_HI, 32'h0);
    apb_release();
    repeat (6) send_item(CMD_DRAIN, $urandom());

    // An order entry naming a dimension that is not in use.
    apply_config(3'd2, 13'd1, 13'd1, 13'd1, 13'd1, 8'hEC);
    send_item(CMD_DRAIN, $urandom());
    send_item(CMD_LOAD, $urandom());
    send_item(CMD_DRAIN, $urandom());

    // A tensor one element larger than the buffer.
    apply_config(3'd1, 13'd4097, 13'd1, 13'd1, 13'd1, 8'hE4);
    send_item(CMD_LOAD, $urandom());
    send_item(CMD_DRAIN, $urandom());

    while (items_sent < ITEM_TARGET) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 4);
        foreach (sz[d]) sz[d] = 13'($urandom_range(0, 8191));
        if (n == 1) begin
          sz[0] = 13'($urandom_range(4097, 8191));
        end else begin
          sz[0] = 13'($urandom_range(2049, 8191));
          sz[1] = 13'($urandom_range(2, 8191));
        end
        ord = $urandom_range(0, 1) ? 8'hE4 : 8'($urandom_range(0, 255));
        apply_config(3'(n), sz[0], sz[1], sz[2], sz[3], ord);
        repeat ($urandom_range(4, 12))
          send_item(tpe_cmd_e'($urandom_range(0, 1)), $urandom());
      end else if (kind <= 2) begin
        apply_config(3'($urandom_range(0, 7)), 13'($urandom_range(0, 3)),
                     13'($urandom_range(0, 3)), 13'($urandom_range(0, 3)),
                     13'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(10, 60))
          send_item(($urandom_range(0, 4) < 3) ? CMD_LOAD : CMD_DRAIN, $urandom());
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < MAX_DIMS; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        ord = 8'($urandom());
        for (int i = 0; i < n; i++) ord[2*i +: 2] = 2'(perm[i]);
        nd = 3'(n);
        if (n == 1 && $urandom_range(0, 3) == 0) nd = 3'd0;
        if (n == 4 && $urandom_range(0, 3) == 0) nd = 3'($urandom_range(5, 7));
        case (n)
          1: cap = 64;
          2: cap = 8;
          3: cap = 4;
          default: cap = 3;
        endcase
        for (int d = 0; d < MAX_DIMS; d++) begin
          if (d >= n) sz[d] = 13'($urandom_range(0, 8191));
          else if ($urandom_range(0, 11) == 0) sz[d] = 13'd0;
          else sz[d] = 13'($urandom_range(1, cap));
        end
        apply_config(nd, sz[0], sz[1], sz[2], sz[3], ord);
        total = tracker.elements_in_tensor();
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) send_item(CMD_DRAIN, $urandom());
        repeat (total) send_item(CMD_LOAD, $urandom());
        if ($urandom_range(0, 4) == 0) settle();
        repeat (total * $urandom_range(1, 2) + $urandom_range(0, 2))
          send_item(CMD_DRAIN, $urandom());
        if ($urandom_range(0, 3) == 0) begin
          repeat (total) send_item(CMD_LOAD, $urandom());
          repeat (total) send_item(CMD_DRAIN, $urandom());
        end
      end
    end

    // An 8 by 8 transpose, drained completely and into the replay.
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    apply_config(3'd2, 13'd8, 13'd8, 13'($urandom_range(0, 8191)),
                 13'($urandom_range(0, 8191)), 8'hE1);
    repeat (64) send_item(CMD_LOAD, $urandom());
    repeat (64 + 2) send_item(CMD_DRAIN, $urandom());

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tensor_permute_engine_test: done, clean");
    end else begin
      $display("tensor_permute_engine_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tpe_pkg.sv
sv/tpe_cfg.sv
sv/tpe_core.sv
sv/tensor_permute_engine.sv
test/tensor_permute_engine_test.sv
